### hdl/ctb_pkg.sv
// Shared types and constants of the cascadable timer bank.
`default_nettype none

package ctb_pkg;

   // Item kinds carried in the kind field; code 3 is unused.
   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_READ  = 2'd1,
      KIND_WRITE = 2'd2
   } kind_type;

   // Register halves selected by reg_select.
   localparam logic REG_COUNTER = 1'b0;
   localparam logic REG_CONTROL = 1'b1;

   // Control byte layout.
   localparam logic [7:0] CTRL_KEEP        = 8'hC7;
   localparam int         CTRL_ENABLE_BIT  = 7;
   localparam int         CTRL_IRQ_BIT     = 6;
   localparam int         CTRL_CASCADE_BIT = 2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  timer_select;
      logic        reg_select;
      logic [15:0] write_data;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] read_data;
      logic [3:0]  irq_mask;
   } rsp_payload_type;

   // Command from the top level to one timer cell.
   typedef struct packed {
      logic        tick;
      logic        wr_reload;
      logic        wr_control;
      logic [15:0] data;
   } cell_cmd_type;

   // Status from one timer cell back to the top level.
   typedef struct packed {
      logic [15:0] count;
      logic [7:0]  control;
      logic        irq;
   } cell_status_type;

   // Number of ticks per counter step for each prescaler select.
   function automatic logic [10:0] prescale_span(input logic [1:0] sel);
      logic [10:0] span;
      case (sel)
         2'd0:    span = 11'd1;
         2'd1:    span = 11'd64;
         2'd2:    span = 11'd256;
         2'd3:    span = 11'd1024;
         default: span = 11'd1;
      endcase
      return span;
   endfunction

endpackage

`default_nettype wire

### hdl/ctb_cell.sv
// One timer cell: counter, reload, control byte and prescaler phase.
`default_nettype none

module ctb_cell
   import ctb_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            cascade_capable,
   input  wire cell_cmd_type    cmd,
   input  wire logic            carry_in,
   output logic                 carry_out,
   output cell_status_type      status
);

   logic [15:0] count_ff,   count_in;
   logic [15:0] reload_ff,  reload_in;
   logic [7:0]  control_ff, control_in;
   logic [9:0]  phase_ff,   phase_in;

   logic        enable;
   logic        on_prescaler;
   logic        on_cascade;
   logic [10:0] phase_next;
   logic        phase_hit;
   logic        bump;
   logic        overflow;
   logic [7:0]  new_control;

   always_comb begin
      enable       = control_ff[CTRL_ENABLE_BIT];
      on_prescaler = enable && !(cascade_capable && control_ff[CTRL_CASCADE_BIT]);
      on_cascade   = enable && cascade_capable && control_ff[CTRL_CASCADE_BIT];
      phase_next   = {1'b0, phase_ff} + 11'd1;
      phase_hit    = phase_next >= prescale_span(control_ff[1:0]);
      bump         = cmd.tick && (on_prescaler ? phase_hit : (carry_in && on_cascade));
      overflow     = bump && (count_ff == 16'hFFFF);
      carry_out    = overflow;
      new_control  = cmd.data[7:0] & CTRL_KEEP;

      count_in   = count_ff;
      reload_in  = reload_ff;
      control_in = control_ff;
      phase_in   = phase_ff;

      if (cmd.tick && on_prescaler) begin
         phase_in = phase_hit ? 10'd0 : phase_next[9:0];
      end
      if (bump) begin
         if (overflow) begin
            count_in = reload_ff;
            phase_in = 10'd0;
         end else begin
            count_in = count_ff + 16'd1;
         end
      end
      if (cmd.wr_reload) begin
         reload_in = cmd.data;
      end
      if (cmd.wr_control) begin
         if (!enable && new_control[CTRL_ENABLE_BIT]) begin
            count_in = reload_ff;
         end
         control_in = new_control;
         phase_in   = 10'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         reload_ff  <= '0;
         control_ff <= '0;
         phase_ff   <= '0;
      end else begin
         count_ff   <= count_in;
         reload_ff  <= reload_in;
         control_ff <= control_in;
         phase_ff   <= phase_in;
      end
   end

   assign status.count   = count_ff;
   assign status.control = control_ff;
   assign status.irq     = overflow && control_ff[CTRL_IRQ_BIT];

endmodule

`default_nettype wire

### hdl/ctb_out_buffer.sv
// Output register with a skid stage for the result channel.
`default_nettype none

module ctb_out_buffer
   import ctb_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   input  wire rsp_payload_type in_data,
   output logic                 full,
   output logic                 out_valid,
   output rsp_payload_type      out_data,
   input  wire logic            out_stall
);

   logic            out_valid_ff;
   logic            skid_valid_ff;
   rsp_payload_type out_data_ff;
   rsp_payload_type skid_data_ff;
   logic            out_take;

   assign out_take = out_valid_ff && !out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (skid_valid_ff) begin
            if (out_take) begin
               out_data_ff   <= skid_data_ff;
               skid_valid_ff <= 1'b0;
            end
         end else if (in_valid) begin
            if (!out_valid_ff || out_take) begin
               out_data_ff  <= in_data;
               out_valid_ff <= 1'b1;
            end else begin
               skid_data_ff  <= in_data;
               skid_valid_ff <= 1'b1;
            end
         end else if (out_take) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   // A held skid entry always sits behind a valid output.
   assert property (@(posedge clock) disable iff (reset) skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without a valid output");

   // No new result may arrive while the skid stage is occupied.
   assert property (@(posedge clock) disable iff (reset) !(in_valid && skid_valid_ff))
      else $error("result arrived while skid stage was full");

   // After a result arrives, the output is valid on the next cycle.
   assert property (@(posedge clock) disable iff (reset) in_valid |=> out_valid_ff)
      else $error("accepted result not presented");

   // A skid entry stays put until the output is taken.
   assert property (@(posedge clock) disable iff (reset)
                    (skid_valid_ff && !out_take) |=> skid_valid_ff)
      else $error("skid entry lost while output stalled");

endmodule

`default_nettype wire

### hdl/cascadable_timer_bank_core.sv
// Top level of the cascadable timer bank: a chain of timer cells and a result buffer.
//
// The block holds TIMER_COUNT 16-bit up-counting timers. Each request transfer
// is a tick, a register read or a register write, and each one produces
// exactly one response transfer carrying read_data and irq_mask.
// A tick advances every prescaled timer; an overflow ripples along the chain
// of cells to the next count-up timer within the same tick, so a whole
// cascade settles in the same cycle as the tick.
// Reads return the counter (reg_select 0) or the control byte (reg_select 1).
// Writes set the reload value or the control byte; a control write restarts
// the prescaler and loads the counter from the reload value on a rising enable.
// Each response is registered in the output register or the skid stage, and the block
// takes one request transfer per cycle for as long as responses are taken.
// The response side has an output register plus a one-entry skid stage, so a
// request is still accepted in the cycle the receiver first stalls; req_stall
// rises only once the skid stage is occupied, and it is a registered signal.
// Synchronous reset clears all counters, reload values, control bytes and
// prescaler phases to zero and empties the response buffer.
`default_nettype none

module cascadable_timer_bank_core
   import ctb_pkg::*;
#(
   parameter int TIMER_COUNT = 4
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire req_payload_type req_payload,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output rsp_payload_type      rsp_payload
);

   // Number of timers that can report an interrupt in the four-bit mask.
   localparam int IRQ_TIMERS = (TIMER_COUNT < 4) ? TIMER_COUNT : 4;

   logic            req_accept;
   logic            is_tick;
   logic            is_read;
   logic            is_write;
   logic            buffer_full;
   rsp_payload_type result;

   // carry[i] is the overflow of cell i-1 into cell i; cell 0 sees no carry.
   logic [TIMER_COUNT:0]   carry;
   logic [TIMER_COUNT-1:0] sel_hit;
   cell_cmd_type           cell_cmd    [TIMER_COUNT];
   cell_status_type        cell_status [TIMER_COUNT];

   assign req_stall  = buffer_full;
   assign req_accept = req_valid && !req_stall;
   assign is_tick    = req_payload.kind == KIND_TICK;
   assign is_read    = req_payload.kind == KIND_READ;
   assign is_write   = req_payload.kind == KIND_WRITE;
   assign carry[0]   = 1'b0;

   for (genvar i = 0; i < TIMER_COUNT; i++) begin : g_cell
      // Timers beyond the reach of timer_select are never addressed.
      assign sel_hit[i] = 32'(req_payload.timer_select) == 32'(i);

      always_comb begin
         cell_cmd[i].tick       = req_accept && is_tick;
         cell_cmd[i].wr_reload  = req_accept && is_write && sel_hit[i] &&
                                  (req_payload.reg_select == REG_COUNTER);
         cell_cmd[i].wr_control = req_accept && is_write && sel_hit[i] &&
                                  (req_payload.reg_select == REG_CONTROL);
         cell_cmd[i].data       = req_payload.write_data;
      end

      // Timer 0 always runs from its prescaler, whatever its count-up bit says.
      ctb_cell u_cell (
         .clock           (clock),
         .reset           (reset),
         .cascade_capable (1'(i != 0)),
         .cmd             (cell_cmd[i]),
         .carry_in        (carry[i]),
         .carry_out       (carry[i+1]),
         .status          (cell_status[i])
      );
   end

   // The read mux and the interrupt mask are built from the cell status words
   // sampled before this item's update, matching the order of the behavior.
   always_comb begin
      result = '0;
      for (int i = 0; i < TIMER_COUNT; i++) begin
         if (is_read && sel_hit[i]) begin
            result.read_data = result.read_data |
               ((req_payload.reg_select == REG_CONTROL) ?
                {8'd0, cell_status[i].control} : cell_status[i].count);
         end
      end
      // Only the four lowest timers report interrupts.
      for (int i = 0; i < IRQ_TIMERS; i++) begin
         result.irq_mask[i] = cell_status[i].irq;
      end
      if (!is_tick) begin
         result.irq_mask = '0;
      end
   end

   ctb_out_buffer u_out_buffer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept),
      .in_data   (result),
      .full      (buffer_full),
      .out_valid (rsp_valid),
      .out_data  (rsp_payload),
      .out_stall (rsp_stall)
   );

   // Interrupts are only ever reported on a tick.
   assert property (@(posedge clock) disable iff (reset)
                    (!is_tick) |-> (result.irq_mask == 4'd0))
      else $error("interrupt reported outside a tick");

   // A read result is zero on anything that is not a read.
   assert property (@(posedge clock) disable iff (reset)
                    (!is_read) |-> (result.read_data == 16'd0))
      else $error("read data driven outside a read");

   // After every accepted request, a response is valid on the next cycle.
   assert property (@(posedge clock) disable iff (reset) req_accept |=> rsp_valid)
      else $error("accepted request produced no response");

endmodule

`default_nettype wire
